[src/pattern_occurrence_counter_core_defines.svh]
// Assertion macros for the pattern occurrence counter.
// No dependencies; included by the modules that carry assertions.
`ifndef PATTERN_OCCURRENCE_COUNTER_CORE_DEFINES_SVH
`define PATTERN_OCCURRENCE_COUNTER_CORE_DEFINES_SVH

// condition holds at every edge out of reset
`define POC_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// trigger at one edge implies result at the next edge
`define POC_ASSERT_NEXT(label, clk, rst, trig, res, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (res)) else $error(msg);

`endif

[src/poc_pkg.sv]
// Shared types and constants for the pattern occurrence counter.
// No dependencies.
package poc_pkg;

  localparam int PATTERN_MAX_DEF = 16;
  localparam int WORD_WIDTH_DEF  = 32;
  localparam int COUNT_W         = 32;
  localparam int LEN_CFG_W       = 5;
  localparam int IN_WORD_W       = 32;
  localparam int SLOT_W          = 4;

  localparam logic MODE_PATTERN = 1'b0;
  localparam logic MODE_TEXT    = 1'b1;

  // per-cycle controls broadcast to every cell
  typedef struct packed {
    logic shift;   // text item accepted: window moves one cell
    logic clear;   // end of stream: window emptied
    logic rotate;  // pattern ring steps one cell toward higher index
    logic pat_we;  // pattern item accepted with a slot in range
  } cell_ctl_t;

endpackage

[src/poc_cell.sv]
// One cell of the match chain: a window word with its valid bit and one
// word of the pattern ring, plus the compare for this position. Uses poc_pkg.
module poc_cell import poc_pkg::*; #(
  parameter int IDX        = 0,
  parameter int WORD_WIDTH = WORD_WIDTH_DEF,
  parameter int LEN_W      = 5,
  parameter int OFF_W      = 4
) (
  input  logic                  clk,
  input  logic                  rst,
  input  cell_ctl_t             ctl,
  input  logic [LEN_W-1:0]      eff_len,
  input  logic [OFF_W-1:0]      wr_idx,
  input  logic [WORD_WIDTH-1:0] wr_data,
  input  logic [WORD_WIDTH-1:0] win_in,
  input  logic                  valid_in,
  input  logic [WORD_WIDTH-1:0] pat_in,
  output logic [WORD_WIDTH-1:0] win,
  output logic                  valid,
  output logic [WORD_WIDTH-1:0] pat,
  output logic                  ok
);

  logic in_use;

  assign in_use = (32'(eff_len) > IDX);
  // compare against the word this cell will hold after the shift
  assign ok = !in_use || (valid_in && (win_in == pat));

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctl.clear) begin
      valid <= 1'b0;
    end else if (ctl.shift) begin
      valid <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      win <= win_in;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.rotate) begin
      pat <= pat_in;
    end else if (ctl.pat_we && (wr_idx == OFF_W'(IDX))) begin
      pat <= wr_data;
    end
  end

endmodule

[src/poc_align.sv]
// Holds pattern_length and the ring offset; steps the pattern ring until
// the newest window cell faces the last used slot. Uses poc_pkg.
module poc_align import poc_pkg::*; #(
  parameter int PATTERN_MAX = PATTERN_MAX_DEF,
  parameter int LEN_W       = 5,
  parameter int OFF_W       = 4
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [LEN_CFG_W-1:0] cfg_len,
  output logic [LEN_W-1:0]     eff_len,
  output logic [OFF_W-1:0]     cur_off,
  output logic                 rotate
);

  logic [LEN_CFG_W-1:0] pattern_length;
  logic [OFF_W-1:0]     target_off;
  logic [OFF_W-1:0]     cur_off_next;

  assign eff_len = (32'(pattern_length) > PATTERN_MAX) ? LEN_W'(PATTERN_MAX)
                                                     : LEN_W'(pattern_length);
  assign target_off = (eff_len == '0) ? '0 : OFF_W'(eff_len - LEN_W'(1));
  assign rotate = (cur_off != target_off);
  assign cur_off_next = (32'(cur_off) == PATTERN_MAX - 1) ? '0 : cur_off + OFF_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_length <= '0;
    end else if (cfg_we) begin
      pattern_length <= cfg_len;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_off <= '0;
    end else if (rotate) begin
      cur_off <= cur_off_next;
    end
  end

endmodule

[src/pattern_occurrence_counter_core.sv]
// Pattern occurrence counter: a chain of compare cells over the text window.
// Uses poc_pkg, poc_align, poc_cell and the assertion macro header.
//
// Usage:
//   cfg channel (cfg_valid/cfg_ready, pattern_length) sets how many pattern
//   slots are in use; cfg_ready is always high. After a write that changes
//   the effective length the pattern ring steps one cell per cycle to line up
//   with the window, and in_ready stays low until the ring is aligned.
//   in channel (in_valid/in_ready): mode 0 items write a pattern slot and give
//   no result; mode 1 items shift a text word into the window and give one
//   result on the out channel (out_valid/out_ready) in the cycle after accept.
//   Throughput is one item per cycle unless rotating or stalled: every window
//   position is compared in parallel, one cell each; count updates that cycle.
//   in_ready follows out_ready while a result is held, so a stalled receiver
//   holds the result and stops intake without losing anything.
//   An item with end_of_text empties the window and the count after its own
//   result. Reset clears pattern_length, window, count and output valid;
//   pattern slots are undefined until written.
module pattern_occurrence_counter_core import poc_pkg::*; #(
  parameter int PATTERN_MAX = PATTERN_MAX_DEF,
  parameter int WORD_WIDTH  = WORD_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [LEN_CFG_W-1:0] pattern_length,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 mode,
  input  logic signed [IN_WORD_W-1:0] word,
  input  logic [SLOT_W-1:0]    slot,
  input  logic                 end_of_text,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 match_ends_here,
  output logic [COUNT_W-1:0]   running_count,
  output logic                 stream_done
);

`include "pattern_occurrence_counter_core_defines.svh"

  localparam int LEN_W = $clog2(PATTERN_MAX + 1);
  localparam int OFF_W = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
  localparam int IW    = OFF_W + SLOT_W + 1;

  logic [LEN_W-1:0]      eff_len;
  logic [OFF_W-1:0]      cur_off;
  logic                  rotate;
  logic                  in_acc;
  logic                  text_acc;
  logic                  slot_ok;
  logic [IW-1:0]         idx_sum;
  logic [IW-1:0]         idx_mod;
  logic [OFF_W-1:0]      wr_idx;
  logic [WORD_WIDTH-1:0] word_ext;
  cell_ctl_t             ctl;
  logic                  hit;
  logic [COUNT_W-1:0]    match_count;
  logic [COUNT_W-1:0]    count_inc;

  logic [WORD_WIDTH-1:0] win     [PATTERN_MAX];
  logic [WORD_WIDTH-1:0] win_in  [PATTERN_MAX];
  logic [WORD_WIDTH-1:0] pat     [PATTERN_MAX];
  logic [WORD_WIDTH-1:0] pat_in  [PATTERN_MAX];
  logic [PATTERN_MAX-1:0] valid;
  logic [PATTERN_MAX-1:0] valid_in;
  logic [PATTERN_MAX-1:0] ok;

  assign cfg_ready = 1'b1;

  poc_align #(
    .PATTERN_MAX(PATTERN_MAX),
    .LEN_W      (LEN_W),
    .OFF_W      (OFF_W)
  ) u_align (
    .clk    (clk),
    .rst    (rst),
    .cfg_we (cfg_valid && cfg_ready),
    .cfg_len(pattern_length),
    .eff_len(eff_len),
    .cur_off(cur_off),
    .rotate (rotate)
  );

  assign in_ready = !rotate && (!out_valid || out_ready);
  assign in_acc   = in_valid && in_ready;
  assign text_acc = in_acc && (mode == MODE_TEXT);

  assign word_ext = WORD_WIDTH'(word);

  // slot s lives in ring cell (cur_off - s) mod PATTERN_MAX
  assign slot_ok = (IW'(slot) < IW'(PATTERN_MAX));
  assign idx_sum = IW'(cur_off) + IW'(PATTERN_MAX) - IW'(slot);
  assign idx_mod = (idx_sum >= IW'(PATTERN_MAX)) ? idx_sum - IW'(PATTERN_MAX) : idx_sum;
  assign wr_idx  = OFF_W'(idx_mod);

  assign ctl.shift  = text_acc;
  assign ctl.clear  = text_acc && end_of_text;
  assign ctl.rotate = rotate;
  assign ctl.pat_we = in_acc && (mode == MODE_PATTERN) && slot_ok;

  for (genvar i = 0; i < PATTERN_MAX; i++) begin : g_cell
    if (i == 0) begin : g_head
      assign win_in[i]   = word_ext;
      assign valid_in[i] = 1'b1;
      assign pat_in[i]   = pat[PATTERN_MAX-1];
    end else begin : g_body
      assign win_in[i]   = win[i-1];
      assign valid_in[i] = valid[i-1];
      assign pat_in[i]   = pat[i-1];
    end

    poc_cell #(
      .IDX       (i),
      .WORD_WIDTH(WORD_WIDTH),
      .LEN_W     (LEN_W),
      .OFF_W     (OFF_W)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .ctl     (ctl),
      .eff_len (eff_len),
      .wr_idx  (wr_idx),
      .wr_data (word_ext),
      .win_in  (win_in[i]),
      .valid_in(valid_in[i]),
      .pat_in  (pat_in[i]),
      .win     (win[i]),
      .valid   (valid[i]),
      .pat     (pat[i]),
      .ok      (ok[i])
    );
  end

  // length zero leaves every cell unused, so every text item hits
  assign hit = &ok;
  assign count_inc = (hit && (match_count != '1)) ? match_count + COUNT_W'(1) : match_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      match_count <= '0;
    end else if (text_acc) begin
      match_count <= end_of_text ? '0 : count_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (text_acc) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (text_acc) begin
      match_ends_here <= hit;
      running_count   <= count_inc;
      stream_done     <= end_of_text;
    end
  end

  `POC_ASSERT_ALWAYS(a_no_intake_while_rotating, clk, rst, !(rotate && in_ready), "item taken while pattern ring misaligned")
  `POC_ASSERT_NEXT(a_text_gives_result, clk, rst, text_acc, out_valid, "text item without result")
  `POC_ASSERT_NEXT(a_eot_clears_count, clk, rst, text_acc && end_of_text, (match_count == '0) && stream_done, "count not cleared at end of stream")
  `POC_ASSERT_NEXT(a_len_zero_hits, clk, rst, text_acc && (eff_len == '0), match_ends_here, "length zero must match every text item")

endmodule
